@@ rtl/ghhmm_pkg.sv @@
// Shared widths, register codes and fixed-point constants for the heading hold block.
package ghhmm_pkg;

  // Port payload widths
  localparam int GYRO_W     = 16;
  localparam int TIME_W     = 16;
  localparam int DRIVE_W    = 16;
  localparam int HEAD_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register field widths
  localparam int DIR_W   = 2;
  localparam int BIAS_W  = 16;
  localparam int DB_W    = 15;
  localparam int SCALE_W = 16;
  localparam int GAIN_W  = 16;
  localparam int LIM_W   = 15;
  localparam int SPEED_W = 15;

  // Datapath widths
  localparam int DIFF_W    = GYRO_W + 2;    // reading minus bias, signed
  localparam int DMAG_W    = GYRO_W;        // |reading - bias| <= 65535
  localparam int MAG_W     = 32;            // shared multiplier operand A
  localparam int MULB_W    = 16;            // shared multiplier operand B
  localparam int PROD_W    = MAG_W + MULB_W;
  localparam int RATE_W    = 28;            // |rate| < 2^27
  localparam int SUM_W     = RATE_W + 1;    // previous rate plus rate
  localparam int DELTA_W   = 26;            // |delta| < 2^25
  localparam int CORR_W    = DRIVE_W;
  localparam int MIX_W     = SPEED_W + 3;   // speed +/- correction before saturation

  // Shared divider: restoring, DIV_RADIX quotient bits per cycle
  localparam int DIV_W      = 40;
  localparam int DIV_RADIX  = 4;
  localparam int DIV_STEPS  = DIV_W / DIV_RADIX;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int REM_W      = 14;

  // rate = round(d * scale * 256 / 10000) = round(d * scale * 16 / 625)
  localparam logic [REM_W-1:0] RATE_DIV   = REM_W'(625);
  localparam logic [DIV_W-1:0] RATE_HALF  = DIV_W'(312);
  localparam int               RATE_SHIFT = 4;

  // delta = round(sum * elapsed / 2000000): add half, drop 7 bits, divide by 15625
  localparam logic [REM_W-1:0] DELTA_DIV   = REM_W'(15625);
  localparam int               DELTA_PW    = 44;   // product bits used
  localparam logic [DELTA_PW:0] DELTA_HALF = (DELTA_PW + 1)'(1000000);
  localparam int               DELTA_SHIFT = 7;

  // correction = round(heading * gain / 2^17)
  localparam int                CORR_SHIFT = 17;
  localparam logic [PROD_W-1:0] CORR_HALF  = PROD_W'(65536);
  localparam int                CORR_Q_W   = PROD_W - CORR_SHIFT;

  // Saturation limits
  localparam logic signed [MIX_W-1:0] DRIVE_MAX = MIX_W'((1 << (DRIVE_W - 1)) - 1);
  localparam logic signed [MIX_W-1:0] DRIVE_MIN = -MIX_W'(1 << (DRIVE_W - 1));

  // Register indexes on the configuration channel
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIRECTION        = 3'd0,
    REG_GYRO_BIAS        = 3'd1,
    REG_DEAD_BAND        = 3'd2,
    REG_RATE_SCALE       = 3'd3,
    REG_HEADING_GAIN     = 3'd4,
    REG_CORRECTION_LIMIT = 3'd5,
    REG_MOVE_SPEED       = 3'd6
  } cfg_reg_t;

  // Travel direction codes
  typedef enum logic [DIR_W-1:0] {
    DIR_FORWARD = 2'd0,
    DIR_BACK    = 2'd1,
    DIR_RIGHT   = 2'd2,
    DIR_LEFT    = 2'd3
  } dir_t;

  // Register reset values
  localparam logic signed [BIAS_W-1:0] GYRO_BIAS_RST   = '0;
  localparam logic [DB_W-1:0]          DEAD_BAND_RST   = DB_W'(50);
  localparam logic [SCALE_W-1:0]       RATE_SCALE_RST  = SCALE_W'(38212);
  localparam logic [GAIN_W-1:0]        HEAD_GAIN_RST   = GAIN_W'(655);
  localparam logic [LIM_W-1:0]         CORR_LIMIT_RST  = LIM_W'(3277);
  localparam logic [SPEED_W-1:0]       MOVE_SPEED_RST  = SPEED_W'(16384);

endpackage

@@ rtl/ghhmm_if.sv @@
// Channel interfaces: gyro input beats, wheel drive result beats, register writes.

interface ghhmm_gyro_if
  import ghhmm_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [GYRO_W-1:0] gyro_reading;
  logic [TIME_W-1:0]        elapsed_us;

  modport source (output valid, output gyro_reading, output elapsed_us, input ready);
  modport sink   (input valid, input gyro_reading, input elapsed_us, output ready);
endinterface

interface ghhmm_drive_if
  import ghhmm_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive_front_left;
  logic signed [DRIVE_W-1:0] drive_front_right;
  logic signed [DRIVE_W-1:0] drive_rear_left;
  logic signed [DRIVE_W-1:0] drive_rear_right;
  logic signed [HEAD_W-1:0]  heading_deg;

  modport source (output valid, output drive_front_left, output drive_front_right,
                  output drive_rear_left, output drive_rear_right, output heading_deg,
                  input ready);
  modport sink   (input valid, input drive_front_left, input drive_front_right,
                  input drive_rear_left, input drive_rear_right, input heading_deg,
                  output ready);
endinterface

interface ghhmm_cfg_if
  import ghhmm_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/gyro_heading_hold_mecanum_mix.sv @@
// Gyro heading hold: bias, deadband, rate scaling, trapezoid heading, mecanum drive mix.
//
// Channels: gyro (sink) takes one beat per control step carrying the averaged
// gyro reading and the microseconds since the previous step. drive (source)
// returns one beat per input beat: four saturated Q1.15 wheel drives and the
// Q16.16 heading after the step. cfg (sink) writes the seven registers; it is
// always ready and is meant to be written only while the block is idle.
// The sequencer runs one 32x16 multiplier three times and one
// 4-bit-per-cycle restoring divider twice for every beat; gyro.ready is
// high only in the idle state, so a new beat is taken only once the last
// one has been worked through.
// Reset (synchronous, rst high) clears heading and the stored turn rate,
// loads the register defaults and drops drive.valid.
// The result sits in an output register: while the receiver stalls, the next
// gyro beat is still taken and worked on, and the sequencer waits in its
// final mix step until the held result is taken.
module gyro_heading_hold_mecanum_mix
  import ghhmm_pkg::*;
(
  input logic           clk,
  input logic           rst,
  ghhmm_gyro_if.sink    gyro,
  ghhmm_drive_if.source drive,
  ghhmm_cfg_if.sink     cfg
);

  typedef enum logic [3:0] {
    S_IDLE, S_DEAD, S_MUL_RATE, S_LD_RATE, S_DIV_RATE, S_SUM, S_ABS_SUM,
    S_MUL_DELTA, S_LD_DELTA, S_DIV_DELTA, S_HEAD, S_ABS_HEAD, S_MUL_CORR,
    S_CORR, S_MIX
  } state_t;

  // Configuration registers
  dir_t                      direction;
  logic signed [BIAS_W-1:0]  gyro_bias;
  logic [DB_W-1:0]           dead_band;
  logic [SCALE_W-1:0]        rate_scale;
  logic [GAIN_W-1:0]         heading_gain;
  logic [LIM_W-1:0]          correction_limit;
  logic [SPEED_W-1:0]        move_speed;

  // Sequencer and datapath registers
  state_t                    state;
  logic signed [DIFF_W-1:0]  diff;
  logic [TIME_W-1:0]         elapsed;
  logic [MAG_W-1:0]          op_mag;
  logic                      op_neg;
  logic [PROD_W-1:0]         prod;
  logic [DIV_W-1:0]          div_num;
  logic [REM_W-1:0]          div_rem;
  logic [DIV_CNT_W-1:0]      div_cnt;
  logic signed [RATE_W-1:0]  rate;
  logic signed [RATE_W-1:0]  prev_rate;
  logic signed [SUM_W-1:0]   rate_sum;
  logic signed [DELTA_W-1:0] delta;
  logic signed [HEAD_W-1:0]  heading;
  logic signed [CORR_W-1:0]  corr;

  // Output register
  logic                      out_valid;
  logic signed [DRIVE_W-1:0] out_fl;
  logic signed [DRIVE_W-1:0] out_fr;
  logic signed [DRIVE_W-1:0] out_rl;
  logic signed [DRIVE_W-1:0] out_rr;
  logic signed [HEAD_W-1:0]  out_heading;

  // Combinational helpers
  logic [DIFF_W-1:0]         diff_abs;
  logic [MULB_W-1:0]         mul_b;
  logic [PROD_W-1:0]         prod_next;
  logic [REM_W-1:0]          divisor;
  logic [REM_W-1:0]          rem_next;
  logic [DIV_W-1:0]          num_next;
  logic [REM_W:0]            trial;
  logic                      div_last;
  logic [SUM_W-1:0]          sum_abs;
  logic [DELTA_PW:0]         delta_round;
  logic signed [HEAD_W:0]    head_sum;
  logic signed [HEAD_W-1:0]  head_sat;
  logic [PROD_W-1:0]         corr_round;
  logic [CORR_Q_W-1:0]       corr_q;
  logic [LIM_W-1:0]          corr_mag;
  logic signed [MIX_W-1:0]   mix_s;
  logic signed [MIX_W-1:0]   mix_c;
  logic signed [MIX_W-1:0]   s_plus_c;
  logic signed [MIX_W-1:0]   s_minus_c;
  logic                      in_beat;
  logic                      out_free;

  function automatic logic signed [DRIVE_W-1:0] sat_drive(input logic signed [MIX_W-1:0] v);
    logic signed [DRIVE_W-1:0] r;
    if (v > DRIVE_MAX)      r = DRIVE_W'(DRIVE_MAX);
    else if (v < DRIVE_MIN) r = DRIVE_W'(DRIVE_MIN);
    else                    r = DRIVE_W'(v);
    return r;
  endfunction

  // Handshakes
  assign gyro.ready = (state == S_IDLE);
  assign cfg.ready  = 1'b1;
  assign in_beat    = gyro.valid && gyro.ready;
  assign out_free   = !out_valid || drive.ready;

  assign drive.valid             = out_valid;
  assign drive.drive_front_left  = out_fl;
  assign drive.drive_front_right = out_fr;
  assign drive.drive_rear_left   = out_rl;
  assign drive.drive_rear_right  = out_rr;
  assign drive.heading_deg       = out_heading;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      direction        <= DIR_FORWARD;
      gyro_bias        <= GYRO_BIAS_RST;
      dead_band        <= DEAD_BAND_RST;
      rate_scale       <= RATE_SCALE_RST;
      heading_gain     <= HEAD_GAIN_RST;
      correction_limit <= CORR_LIMIT_RST;
      move_speed       <= MOVE_SPEED_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_DIRECTION:        direction        <= dir_t'(cfg.data[DIR_W-1:0]);
        REG_GYRO_BIAS:        gyro_bias        <= signed'(cfg.data[BIAS_W-1:0]);
        REG_DEAD_BAND:        dead_band        <= cfg.data[DB_W-1:0];
        REG_RATE_SCALE:       rate_scale       <= cfg.data[SCALE_W-1:0];
        REG_HEADING_GAIN:     heading_gain     <= cfg.data[GAIN_W-1:0];
        REG_CORRECTION_LIMIT: correction_limit <= cfg.data[LIM_W-1:0];
        REG_MOVE_SPEED:       move_speed       <= cfg.data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // Magnitude of reading minus bias
  assign diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

  // Shared multiplier, operand B picked by phase
  always_comb begin
    unique case (state)
      S_MUL_RATE:  mul_b = rate_scale;
      S_MUL_DELTA: mul_b = elapsed;
      default:     mul_b = heading_gain;
    endcase
  end
  assign prod_next = op_mag * mul_b;

  // Shared divider: DIV_RADIX restoring steps per cycle, quotient shifts into div_num
  assign divisor  = (state == S_DIV_RATE) ? RATE_DIV : DELTA_DIV;
  assign div_last = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
  always_comb begin
    rem_next = div_rem;
    num_next = div_num;
    trial    = '0;
    for (int k = 0; k < DIV_RADIX; k++) begin
      trial    = {rem_next, num_next[DIV_W-1]};
      num_next = {num_next[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_next    = REM_W'(trial - {1'b0, divisor});
        num_next[0] = 1'b1;
      end else begin
        rem_next = trial[REM_W-1:0];
      end
    end
  end

  // Rate sum magnitude and rounded delta dividend
  assign sum_abs     = rate_sum[SUM_W-1] ? SUM_W'(-rate_sum) : SUM_W'(rate_sum);
  assign delta_round = {1'b0, prod[DELTA_PW-1:0]} + DELTA_HALF;

  // Heading update with saturation at the 32-bit limits
  assign head_sum = {heading[HEAD_W-1], heading} + (HEAD_W + 1)'(delta);
  always_comb begin
    if (head_sum[HEAD_W] != head_sum[HEAD_W-1])
      head_sat = head_sum[HEAD_W] ? {1'b1, {(HEAD_W-1){1'b0}}} : {1'b0, {(HEAD_W-1){1'b1}}};
    else
      head_sat = head_sum[HEAD_W-1:0];
  end

  // Correction magnitude, rounded and clamped
  assign corr_round = prod + CORR_HALF;
  assign corr_q     = corr_round[PROD_W-1:CORR_SHIFT];
  assign corr_mag   = (corr_q > CORR_Q_W'(correction_limit)) ? correction_limit
                                                            : corr_q[LIM_W-1:0];

  // Mix terms
  assign mix_s     = MIX_W'(move_speed);
  assign mix_c     = MIX_W'(corr);
  assign s_plus_c  = mix_s + mix_c;
  assign s_minus_c = mix_s - mix_c;

  // Sequencer with datapath and output registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      heading   <= '0;
      prev_rate <= '0;
    end else begin
      if (drive.valid && drive.ready) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_beat) begin
            diff    <= DIFF_W'(gyro.gyro_reading) - DIFF_W'(gyro_bias);
            elapsed <= gyro.elapsed_us;
            state   <= S_DEAD;
          end
        end
        S_DEAD: begin
          // readings strictly inside the deadband count as zero rate
          if (diff_abs < DIFF_W'(dead_band)) op_mag <= '0;
          else                               op_mag <= MAG_W'(diff_abs[DMAG_W-1:0]);
          op_neg <= diff[DIFF_W-1];
          state  <= S_MUL_RATE;
        end
        S_MUL_RATE: begin
          prod  <= prod_next;
          state <= S_LD_RATE;
        end
        S_LD_RATE: begin
          div_num <= DIV_W'({prod[MAG_W-1:0], {RATE_SHIFT{1'b0}}}) + RATE_HALF;
          div_rem <= '0;
          div_cnt <= '0;
          state   <= S_DIV_RATE;
        end
        S_DIV_RATE: begin
          div_num <= num_next;
          div_rem <= rem_next;
          div_cnt <= div_cnt + 1'b1;
          if (div_last) begin
            rate  <= op_neg ? -RATE_W'(num_next[RATE_W-2:0]) : RATE_W'(num_next[RATE_W-2:0]);
            state <= S_SUM;
          end
        end
        S_SUM: begin
          rate_sum <= SUM_W'(prev_rate) + SUM_W'(rate);
          state    <= S_ABS_SUM;
        end
        S_ABS_SUM: begin
          op_mag <= MAG_W'(sum_abs[SUM_W-2:0]);
          op_neg <= rate_sum[SUM_W-1];
          state  <= S_MUL_DELTA;
        end
        S_MUL_DELTA: begin
          prod  <= prod_next;
          state <= S_LD_DELTA;
        end
        S_LD_DELTA: begin
          div_num <= DIV_W'(delta_round[DELTA_PW:DELTA_SHIFT]);
          div_rem <= '0;
          div_cnt <= '0;
          state   <= S_DIV_DELTA;
        end
        S_DIV_DELTA: begin
          div_num <= num_next;
          div_rem <= rem_next;
          div_cnt <= div_cnt + 1'b1;
          if (div_last) begin
            delta <= op_neg ? -DELTA_W'(num_next[DELTA_W-2:0])
                            : DELTA_W'(num_next[DELTA_W-2:0]);
            state <= S_HEAD;
          end
        end
        S_HEAD: begin
          heading   <= head_sat;
          prev_rate <= rate;
          state     <= S_ABS_HEAD;
        end
        S_ABS_HEAD: begin
          // most negative heading maps to 2^31, which still fits unsigned
          op_mag <= heading[HEAD_W-1] ? MAG_W'(-heading) : MAG_W'(heading);
          op_neg <= heading[HEAD_W-1];
          state  <= S_MUL_CORR;
        end
        S_MUL_CORR: begin
          prod  <= prod_next;
          state <= S_CORR;
        end
        S_CORR: begin
          corr  <= op_neg ? -CORR_W'(corr_mag) : CORR_W'(corr_mag);
          state <= S_MIX;
        end
        S_MIX: begin
          // hold here until the previous result beat is gone
          if (out_free) begin
            unique case (direction)
              DIR_FORWARD: begin
                out_fl <= sat_drive(-s_minus_c);
                out_fr <= sat_drive(-s_plus_c);
                out_rl <= sat_drive(-s_minus_c);
                out_rr <= sat_drive(-s_plus_c);
              end
              DIR_BACK: begin
                out_fl <= sat_drive(s_plus_c);
                out_fr <= sat_drive(s_minus_c);
                out_rl <= sat_drive(s_plus_c);
                out_rr <= sat_drive(s_minus_c);
              end
              DIR_RIGHT: begin
                out_fl <= sat_drive(s_plus_c);
                out_fr <= sat_drive(-s_plus_c);
                out_rl <= sat_drive(-s_minus_c);
                out_rr <= sat_drive(s_minus_c);
              end
              DIR_LEFT: begin
                out_fl <= sat_drive(-s_minus_c);
                out_fr <= sat_drive(s_minus_c);
                out_rl <= sat_drive(s_plus_c);
                out_rr <= sat_drive(-s_plus_c);
              end
            endcase
            out_heading <= heading;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/ghhmm_checker.sv @@
// Port-level checks for the heading hold block, bound onto the top level.
module ghhmm_checker
  import ghhmm_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [DRIVE_W-1:0] out_fl,
  input logic signed [DRIVE_W-1:0] out_fr,
  input logic signed [DRIVE_W-1:0] out_rl,
  input logic signed [DRIVE_W-1:0] out_rr,
  input logic signed [HEAD_W-1:0]  out_heading,
  input logic                      cfg_valid,
  input logic                      cfg_ready
);

  // A stalled result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_fl) && $stable(out_fr) &&
                                $stable(out_rl) && $stable(out_rr) && $stable(out_heading))
    else $error("result beat changed while stalled");

  // One item at a time: no new gyro beat right after one is taken
  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("gyro beat taken while busy");

  // A new result appears as the block returns to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result raised while sequencer busy");

  // Reset leaves no result pending
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("state not cleared by reset");

  // Register writes are never back-pressured
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("register write stalled");

endmodule

bind gyro_heading_hold_mecanum_mix ghhmm_checker u_ghhmm_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (gyro.valid),
  .in_ready    (gyro.ready),
  .out_valid   (drive.valid),
  .out_ready   (drive.ready),
  .out_fl      (drive.drive_front_left),
  .out_fr      (drive.drive_front_right),
  .out_rl      (drive.drive_rear_left),
  .out_rr      (drive.drive_rear_right),
  .out_heading (drive.heading_deg),
  .cfg_valid   (cfg.valid),
  .cfg_ready   (cfg.ready)
);

@@ dv/tb_gyro_heading_hold_mecanum_mix.sv @@
// Self-checking testbench for the gyro heading hold and mecanum drive mix block.
module tb_gyro_heading_hold_mecanum_mix;
  import ghhmm_pkg::*;

  // Index past the last register: a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int HOLD_CYCLES    = 400;
  localparam int MAX_SHOWN      = 10;
  localparam int SAT_ITEMS      = 650;
  localparam int RAND_PHASES    = 8;
  localparam int RAND_ITEMS     = 60;

  localparam longint HEAD_LO  = -(longint'(1) <<< 31);
  localparam longint HEAD_HI  = (longint'(1) <<< 31) - 1;
  localparam longint DRIVE_LO = -32768;
  localparam longint DRIVE_HI = 32767;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] front_left;
    logic signed [DRIVE_W-1:0] front_right;
    logic signed [DRIVE_W-1:0] rear_left;
    logic signed [DRIVE_W-1:0] rear_right;
    logic signed [HEAD_W-1:0]  heading;
  } drive_beat_t;

  logic clk = 1'b0;
  logic rst;

  ghhmm_gyro_if  gyro_ch();
  ghhmm_drive_if drive_ch();
  ghhmm_cfg_if   cfg_ch();

  gyro_heading_hold_mecanum_mix u_dut (
    .clk   (clk),
    .rst   (rst),
    .gyro  (gyro_ch),
    .drive (drive_ch),
    .cfg   (cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow registers and heading state of the predictor
  dir_t                      sh_direction;
  logic signed [BIAS_W-1:0]  sh_bias;
  logic [DB_W-1:0]           sh_dead_band;
  logic [SCALE_W-1:0]        sh_rate_scale;
  logic [GAIN_W-1:0]         sh_gain;
  logic [LIM_W-1:0]          sh_limit;
  logic [SPEED_W-1:0]        sh_speed;
  logic signed [HEAD_W-1:0]  heading_acc;
  logic signed [HEAD_W-1:0]  last_rate;

  drive_beat_t expected_beats[$];

  int unsigned fail_count;
  int unsigned gyro_beats;
  int unsigned drive_beats;
  int unsigned cfg_writes;
  int unsigned setting_count;
  int unsigned quiet_cycles;

  // Traffic shaping; rx_stally and hold_req are shared with the receiver process
  int unsigned burst_left;
  bit          tx_gappy;
  bit          rx_stally;
  bit          hold_req;

  function automatic longint div_nearest(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void predictor_reset();
    sh_direction  = DIR_FORWARD;
    sh_bias       = GYRO_BIAS_RST;
    sh_dead_band  = DEAD_BAND_RST;
    sh_rate_scale = RATE_SCALE_RST;
    sh_gain       = HEAD_GAIN_RST;
    sh_limit      = CORR_LIMIT_RST;
    sh_speed      = MOVE_SPEED_RST;
    heading_acc   = '0;
    last_rate     = '0;
  endfunction

  function automatic void predictor_write(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_DIRECTION:        sh_direction  = dir_t'(value[DIR_W-1:0]);
      REG_GYRO_BIAS:        sh_bias       = value;
      REG_DEAD_BAND:        sh_dead_band  = value[DB_W-1:0];
      REG_RATE_SCALE:       sh_rate_scale = value;
      REG_HEADING_GAIN:     sh_gain       = value;
      REG_CORRECTION_LIMIT: sh_limit      = value[LIM_W-1:0];
      REG_MOVE_SPEED:       sh_speed      = value[SPEED_W-1:0];
      default: ;
    endcase
  endfunction

  // One control step: rate, trapezoid heading, clamped correction, wheel mix
  function automatic drive_beat_t step_heading_hold(logic signed [GYRO_W-1:0] reading,
                                                    logic [TIME_W-1:0] elapsed);
    longint diff;
    longint rate;
    longint delta;
    longint head;
    longint corr;
    longint speed;
    longint mix [4];
    drive_beat_t beat;
    diff = longint'(reading) - longint'(sh_bias);
    if (diff > -longint'(sh_dead_band) && diff < longint'(sh_dead_band)) diff = 0;
    rate  = div_nearest(diff * longint'(sh_rate_scale) * 256, 10000);
    delta = div_nearest((longint'(last_rate) + rate) * longint'(elapsed), 2000000);
    head  = clamp(longint'(heading_acc) + delta, HEAD_LO, HEAD_HI);
    heading_acc = HEAD_W'(head);
    last_rate   = HEAD_W'(rate);
    corr  = div_nearest(head * longint'(sh_gain), 131072);
    corr  = clamp(corr, -longint'(sh_limit), longint'(sh_limit));
    speed = longint'(sh_speed);
    case (sh_direction)
      DIR_FORWARD: mix = '{corr - speed, -speed - corr, corr - speed, -speed - corr};
      DIR_BACK:    mix = '{speed + corr, speed - corr, speed + corr, speed - corr};
      DIR_RIGHT:   mix = '{speed + corr, -speed - corr, corr - speed, speed - corr};
      default:     mix = '{corr - speed, speed - corr, speed + corr, -speed - corr};
    endcase
    beat.front_left  = DRIVE_W'(clamp(mix[0], DRIVE_LO, DRIVE_HI));
    beat.front_right = DRIVE_W'(clamp(mix[1], DRIVE_LO, DRIVE_HI));
    beat.rear_left   = DRIVE_W'(clamp(mix[2], DRIVE_LO, DRIVE_HI));
    beat.rear_right  = DRIVE_W'(clamp(mix[3], DRIVE_LO, DRIVE_HI));
    beat.heading     = HEAD_W'(head);
    return beat;
  endfunction

  task automatic note_failure(string what, longint want, longint got);
    fail_count++;
    if (fail_count <= MAX_SHOWN)
      $display("MISMATCH beat %0d %s: expected %0d got %0d", drive_beats, what, want, got);
  endtask

  task automatic check_field(string what, longint want, longint got);
    if (want != got) note_failure(what, want, got);
  endtask

  // Result checker: every drive beat against the oldest prediction
  always @(posedge clk) begin
    drive_beat_t want;
    if (!rst && drive_ch.valid && drive_ch.ready) begin
      drive_beats++;
      if (expected_beats.size() == 0) begin
        note_failure("unexpected beat, heading", 0, longint'(drive_ch.heading_deg));
      end else begin
        want = expected_beats.pop_front();
        check_field("drive_front_left", longint'($signed(want.front_left)),
                    longint'(drive_ch.drive_front_left));
        check_field("drive_front_right", longint'($signed(want.front_right)),
                    longint'(drive_ch.drive_front_right));
        check_field("drive_rear_left", longint'($signed(want.rear_left)),
                    longint'(drive_ch.drive_rear_left));
        check_field("drive_rear_right", longint'($signed(want.rear_right)),
                    longint'(drive_ch.drive_rear_right));
        check_field("heading_deg", longint'($signed(want.heading)),
                    longint'(drive_ch.heading_deg));
      end
    end
  end

  // Watchdog: any accepted beat on any channel counts as progress
  always @(posedge clk) begin
    if (rst || (gyro_ch.valid && gyro_ch.ready) || (drive_ch.valid && drive_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: free running, random stall runs, or one long hold-off on request
  initial begin
    int unsigned hold_left;
    int unsigned run_left;
    bit          run_ready;
    hold_left = 0;
    run_left  = 0;
    run_ready = 1'b1;
    drive_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        drive_ch.ready <= 1'b0;
      end else if (!rx_stally) begin
        drive_ch.ready <= 1'b1;
      end else begin
        if (run_left == 0) begin
          run_left  = $urandom_range(1, 40);
          run_ready = ($urandom_range(0, 2) != 0);
        end
        run_left--;
        drive_ch.ready <= run_ready;
      end
    end
  end

  // Send one gyro beat; valid stays high across a burst
  task automatic send_gyro(logic signed [GYRO_W-1:0] reading, logic [TIME_W-1:0] elapsed);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if (tx_gappy) begin
        gyro_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 50)) @(posedge clk);
      end
    end
    burst_left--;
    gyro_ch.valid        <= 1'b1;
    gyro_ch.gyro_reading <= reading;
    gyro_ch.elapsed_us   <= elapsed;
    do @(posedge clk); while (!gyro_ch.ready);
    expected_beats.push_back(step_heading_hold(reading, elapsed));
    gyro_beats++;
  endtask

  // Stop sending and wait for every predicted beat to come back
  task automatic wait_drained();
    gyro_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (expected_beats.size() != 0);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    predictor_write(idx, value);
    cfg_writes++;
    @(posedge clk);
  endtask

  task automatic set_config(dir_t dir, logic [CFG_DATA_W-1:0] bias,
                            logic [CFG_DATA_W-1:0] dead_band, logic [CFG_DATA_W-1:0] scale,
                            logic [CFG_DATA_W-1:0] gain, logic [CFG_DATA_W-1:0] limit,
                            logic [CFG_DATA_W-1:0] speed);
    cfg_write(REG_DIRECTION, CFG_DATA_W'(dir));
    cfg_write(REG_GYRO_BIAS, bias);
    cfg_write(REG_DEAD_BAND, dead_band);
    cfg_write(REG_RATE_SCALE, scale);
    cfg_write(REG_HEADING_GAIN, gain);
    cfg_write(REG_CORRECTION_LIMIT, limit);
    cfg_write(REG_MOVE_SPEED, speed);
    setting_count++;
  endtask

  // Register value: mostly typical, sometimes an extreme
  function automatic logic [CFG_DATA_W-1:0] pick_reg(logic [CFG_DATA_W-1:0] lo_v,
                                                     logic [CFG_DATA_W-1:0] hi_v,
                                                     logic [CFG_DATA_W-1:0] typical);
    case ($urandom_range(0, 7))
      0:       return lo_v;
      1:       return hi_v;
      default: return typical;
    endcase
  endfunction

  // Reading: a quarter straddle the deadband around the bias, the rest full range
  function automatic logic signed [GYRO_W-1:0] rand_reading();
    int span;
    int off;
    if ($urandom_range(0, 3) == 0) begin
      span = int'(sh_dead_band) + 3;
      off  = int'($urandom_range(0, 2 * span)) - span;
      return GYRO_W'(int'(sh_bias) + off);
    end
    return GYRO_W'($urandom);
  endfunction

  function automatic logic [TIME_W-1:0] rand_elapsed();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return TIME_W'($urandom_range(0, 20000));
      default: return TIME_W'($urandom);
    endcase
  endfunction

  // Reset defaults, deadband edges, field extremes, zero elapsed time
  task automatic test_reset_defaults();
    send_gyro(16'sd0, 16'd10000);
    send_gyro(16'sd49, 16'd10000);
    send_gyro(-16'sd49, 16'd10000);
    send_gyro(16'sd50, 16'd10000);
    send_gyro(-16'sd50, 16'd10000);
    send_gyro(16'sh7FFF, 16'hFFFF);
    send_gyro(16'sh8000, 16'hFFFF);
    send_gyro(16'sd1200, 16'd0);
    send_gyro(-16'sd1200, 16'd5000);
    wait_drained();
  endtask

  // Each travel direction with a nonzero heading; unused index write is dropped
  task automatic test_directions();
    dir_t dirs [4];
    dirs = '{DIR_FORWARD, DIR_BACK, DIR_RIGHT, DIR_LEFT};
    cfg_write(REG_NONE, 16'hFFFF);
    foreach (dirs[i]) begin
      cfg_write(REG_DIRECTION, CFG_DATA_W'(dirs[i]));
      send_gyro(16'sd9000, 16'd40000);
      send_gyro(-16'sd3000, 16'd20000);
      wait_drained();
    end
  endtask

  // Zero deadband, then fields at top (bias at bottom), then the reverse
  task automatic test_register_extremes();
    set_config(DIR_FORWARD, 16'sd100, 16'd0, RATE_SCALE_RST, HEAD_GAIN_RST,
               CORR_LIMIT_RST, MOVE_SPEED_RST);
    send_gyro(16'sd100, 16'd10000);
    send_gyro(16'sd101, 16'd10000);
    send_gyro(16'sd99, 16'd10000);
    wait_drained();
    set_config(DIR_BACK, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF);
    send_gyro(16'sh7FFF, 16'hFFFF);
    send_gyro(16'sh7FFF, 16'hFFFF);
    send_gyro(16'sh7FFF, 16'hFFFF);
    send_gyro(16'sh8000, 16'hFFFF);
    wait_drained();
    set_config(DIR_LEFT, 16'h7FFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_gyro(16'sh8000, 16'hFFFF);
    send_gyro(16'sh7FFF, 16'd1);
    send_gyro(16'sd0, 16'd0);
    wait_drained();
  endtask

  // Random register settings per phase, random traffic shape
  task automatic test_random_settings();
    repeat (RAND_PHASES) begin
      wait_drained();
      set_config(dir_t'($urandom_range(DIR_FORWARD, DIR_LEFT)),
                 pick_reg(16'h8000, 16'h7FFF, CFG_DATA_W'($urandom)),
                 pick_reg(16'h0000, 16'h7FFF, CFG_DATA_W'($urandom_range(0, 400))),
                 pick_reg(16'h0000, 16'hFFFF, CFG_DATA_W'($urandom)),
                 pick_reg(16'h0000, 16'hFFFF, CFG_DATA_W'($urandom)),
                 pick_reg(16'h0000, 16'h7FFF, CFG_DATA_W'($urandom_range(0, 16'h7FFF))),
                 pick_reg(16'h0000, 16'h7FFF, CFG_DATA_W'($urandom_range(0, 16'h7FFF))));
      tx_gappy  = ($urandom_range(0, 3) != 0);
      rx_stally = ($urandom_range(0, 3) != 0);
      repeat (RAND_ITEMS) send_gyro(rand_reading(), rand_elapsed());
    end
    wait_drained();
  endtask

  // Full-scale turn both ways until the heading pins at each 32-bit limit
  task automatic test_heading_saturation();
    set_config(dir_t'($urandom_range(DIR_FORWARD, DIR_LEFT)), 16'h8000, DEAD_BAND_RST,
               16'hFFFF, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom_range(0, 16'h7FFF)),
               CFG_DATA_W'($urandom_range(0, 16'h7FFF)));
    tx_gappy  = 1'b1;
    rx_stally = 1'b1;
    repeat (SAT_ITEMS)
      send_gyro(GYRO_W'(16'sh7FFF - $urandom_range(0, 255)),
                TIME_W'(16'hFFFF - $urandom_range(0, 1023)));
    wait_drained();
    cfg_write(REG_GYRO_BIAS, 16'h7FFF);
    repeat (SAT_ITEMS)
      send_gyro(GYRO_W'(16'sh8000 + $urandom_range(0, 255)),
                TIME_W'(16'hFFFF - $urandom_range(0, 1023)));
    wait_drained();
  endtask

  // Long receiver hold-off while beats keep coming back to back
  task automatic test_backpressure();
    tx_gappy = 1'b0;
    hold_req = 1'b1;
    repeat (12) send_gyro(rand_reading(), rand_elapsed());
    wait_drained();
    tx_gappy  = 1'b1;
    rx_stally = 1'b1;
  endtask

  initial begin
    rst                  <= 1'b1;
    gyro_ch.valid        <= 1'b0;
    gyro_ch.gyro_reading <= '0;
    gyro_ch.elapsed_us   <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.index         <= '0;
    cfg_ch.data          <= '0;
    fail_count    = 0;
    gyro_beats    = 0;
    drive_beats   = 0;
    cfg_writes    = 0;
    setting_count = 0;
    burst_left    = 0;
    tx_gappy      = 1'b1;
    rx_stally     = 1'b1;
    hold_req      = 1'b0;
    predictor_reset();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_directions();
    test_register_extremes();
    test_random_settings();
    test_heading_saturation();
    test_backpressure();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_beats.size() != 0)
      note_failure("beats still outstanding", 0, expected_beats.size());

    $display("Run: %0d gyro beats in, %0d drive beats checked, %0d register writes, %0d settings",
             gyro_beats, drive_beats, cfg_writes, setting_count);
    $display("Covered all directions, register extremes, deadband edges, zero elapsed time, %s",
             "heading saturation both ways and a long receiver hold-off");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
